[src/lkv_pkg.sv]
package lkv_pkg;

   localparam int KEY_W       = 16;
   localparam int VALUE_W     = 16;
   localparam int CAP_W       = 5;
   localparam int DEF_ENTRIES = 16;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   localparam logic MODE_GET = 1'b0;
   localparam logic MODE_PUT = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [VALUE_W-1:0] read_value;
      logic               evicted;
   } rsp_type;

   // One lookup handed to the entry store
   typedef struct packed {
      logic    en;
      req_type req;
   } op_type;

endpackage

[src/lkv_store.sv]
module lkv_store
   import lkv_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  op_type           op,
   input  logic [CAP_W-1:0] capacity,
   output rsp_type          rsp
);

   localparam int RANK_W = $clog2(ENTRIES);
   localparam int OCC_W  = $clog2(ENTRIES + 1);

   logic [KEY_W-1:0]   key_ff   [ENTRIES];
   logic [KEY_W-1:0]   key_in   [ENTRIES];
   logic [VALUE_W-1:0] value_ff [ENTRIES];
   logic [VALUE_W-1:0] value_in [ENTRIES];
   logic [RANK_W-1:0]  rank_ff  [ENTRIES];
   logic [RANK_W-1:0]  rank_in  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;

   logic [ENTRIES-1:0] match, victim, valid_left, slot_oh;
   logic               hit, full, do_evict, slot_taken;
   logic [RANK_W-1:0]  hit_rank;
   logic [VALUE_W-1:0] hit_value;
   logic [OCC_W-1:0]   occ_m1;
   logic [31:0]        eff_cap;

   // capacity of zero acts as one, above the entry count as the entry count
   always_comb begin
      if (capacity == '0) begin
         eff_cap = 32'd1;
      end else if (32'(capacity) > ENTRIES) begin
         eff_cap = 32'(ENTRIES);
      end else begin
         eff_cap = 32'(capacity);
      end
   end

   assign occ_m1 = occ_ff - OCC_W'(1);
   assign full   = 32'(occ_ff) >= eff_cap;

   always_comb begin
      hit_rank  = '0;
      hit_value = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         match[i]  = valid_ff[i] && (key_ff[i] == op.req.key);
         // valid ranks are always 0..occ-1, so the oldest has rank occ-1
         victim[i] = valid_ff[i] && (OCC_W'(rank_ff[i]) == occ_m1);
         if (match[i]) begin
            hit_rank  = hit_rank | rank_ff[i];
            hit_value = hit_value | value_ff[i];
         end
      end
      hit = |match;
   end

   assign do_evict   = (op.req.mode == MODE_PUT) && !hit && full;
   assign valid_left = valid_ff & ~(do_evict ? victim : '0);

   // lowest free entry
   always_comb begin
      slot_oh    = '0;
      slot_taken = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!valid_left[i] && !slot_taken) begin
            slot_oh[i] = 1'b1;
            slot_taken = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         key_in[i]   = key_ff[i];
         value_in[i] = value_ff[i];
         rank_in[i]  = rank_ff[i];
      end
      if (op.en) begin
         if (hit) begin
            // promote: younger entries age by one
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_ff[i] && rank_ff[i] < hit_rank) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
               if (match[i]) begin
                  rank_in[i] = '0;
                  if (op.req.mode == MODE_PUT) begin
                     value_in[i] = op.req.value;
                  end
               end
            end
         end else if (op.req.mode == MODE_PUT) begin
            valid_in = valid_left | slot_oh;
            occ_in   = do_evict ? occ_ff : occ_ff + OCC_W'(1);
            for (int i = 0; i < ENTRIES; i++) begin
               if (valid_left[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
               if (slot_oh[i]) begin
                  key_in[i]   = op.req.key;
                  value_in[i] = op.req.value;
                  rank_in[i]  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         occ_ff   <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         valid_ff <= valid_in;
         occ_ff   <= occ_in;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         key_ff[i]   <= key_in[i];
         value_ff[i] <= value_in[i];
      end
   end

   assign rsp.found      = hit;
   assign rsp.read_value = (op.req.mode == MODE_GET && hit) ? hit_value : '0;
   assign rsp.evicted    = do_evict;

endmodule

[src/lru_key_value_cache_top.sv]
// Fully associative key/value cache with least-recently-used replacement.
// Request channel (req_valid/req_ready/req_data): one word per get or put;
//   mode selects get (lookup) or put (insert or update).
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one word per
//   request, in request order: found, read_value (get hit only, else 0),
//   evicted (put that displaced the least recent entry).
// CSR port: csr_wr_en writes csr_wr_data into the capacity register
//   (0 acts as 1, above ENTRIES acts as ENTRIES). Write only while idle.
// Flow: a request taken is captured in the input register; it is looked up
//   and committed as it advances into the response register, from which its
//   response can then be taken.
// Throughput: one word per cycle unless stalled; the parallel tag compare and
//   rank update across all entries sit between the input and response registers.
// Reset: all entries invalid, occupancy zero, capacity back to 16.
// Stall: while rsp_ready is low a held response freezes the input stage;
//   req_ready drops once the input register is also occupied.
module lru_key_value_cache_top
   import lkv_pkg::*;
#(
   parameter int ENTRIES = DEF_ENTRIES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CAP_W-1:0] csr_wr_data
);

   logic             s1_valid_ff, s1_valid_in;
   req_type          s1_req_ff, s1_req_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic [CAP_W-1:0] cap_ff, cap_in;
   logic             advance;
   op_type           op;
   rsp_type          store_rsp;

   // input stage moves on whenever the response register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_valid && req_ready) begin
         s1_valid_in = 1'b1;
         s1_req_in   = req_data;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = store_rsp;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   assign op.en  = advance;
   assign op.req = s1_req_ff;

   lkv_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .capacity (cap_ff),
      .rsp      (store_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
